/* hw/rtl/conv3_pkg.sv */
package conv3_pkg;

    localparam int KERNEL_SIZE    = 3;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int PIX_BITS       = 8;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int MIN_DIM        = 3;

    localparam int FW_BITS      = 11;
    localparam int FH_BITS      = 13;
    localparam int ROW_BITS     = 13;
    localparam int KROW_BITS    = KERNEL_SIZE * COEF_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_BOTTOM = 3'd4;

    localparam logic [FW_BITS-1:0]   FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_BITS-1:0]   FRAME_HEIGHT_RST = 13'd480;
    // 3x3 Gaussian, sigma 0.6, Q2.14: corners 454, edges 1819, center 7294
    localparam logic [KROW_BITS-1:0] KERNEL_OUTER_RST  = 48'd1950034362822;
    localparam logic [KROW_BITS-1:0] KERNEL_CENTER_RST = 48'd7813023532827;

    typedef logic [PIX_BITS-1:0] pix_t;
    // [row][col], row 0 = top, col 0 = left
    typedef pix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_t;
    // one packed row of coefficients per kernel row, left coefficient in low bits
    typedef logic [KERNEL_SIZE-1:0][KROW_BITS-1:0] kern_t;

    typedef struct packed {
        logic valid;
        logic frame_end;
    } tag_t;

endpackage

/* hw/rtl/conv3_ram.sv */
module conv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/conv3_mac.sv */
module conv3_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  conv3_pkg::tag_t   in_tag,
    input  conv3_pkg::win_t   in_win,
    input  conv3_pkg::kern_t  kern,
    output conv3_pkg::tag_t   out_tag,
    output conv3_pkg::pix_t   out_pixel,
    output logic              out_clipped
);
    import conv3_pkg::*;

    localparam int PROD_W = PIX_BITS + 1 + COEF_BITS;
    localparam int RSUM_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RSUM_W-1:0] rsum_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    prod_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] prod_next, prod_reg;
    rsum_t [KERNEL_SIZE-1:0] rsum_next, rsum_reg;
    tag_t  tag1_reg, tag2_reg, tag3_reg;
    sum_t  total;
    sum_t  quot;
    pix_t  pix_next, pix_reg;
    logic  clip_next, clip_reg;

    // stage 1: nine 9x16 signed products
    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                prod_next[r][k] = PROD_W'($signed({1'b0, in_win[r][k]}))
                                * PROD_W'($signed(kern[r][k*COEF_BITS +: COEF_BITS]));
            end
        end
    end

    // stage 2: per-row sums
    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            rsum_next[r] = RSUM_W'(prod_reg[r][0]) + RSUM_W'(prod_reg[r][1])
                         + RSUM_W'(prod_reg[r][2]);
        end
    end

    // stage 3: total, floor (arithmetic shift), saturate
    always_comb begin
        total = SUM_W'(rsum_reg[0]) + SUM_W'(rsum_reg[1]) + SUM_W'(rsum_reg[2]);
        quot  = total >>> COEF_FRAC_BITS;
        if (quot < 0) begin
            pix_next  = '0;
            clip_next = 1'b1;
        end else if (quot > SUM_W'(255)) begin
            pix_next  = '1;
            clip_next = 1'b1;
        end else begin
            pix_next  = quot[PIX_BITS-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else if (en) begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            rsum_reg <= rsum_next;
            pix_reg  <= pix_next;
            clip_reg <= clip_next;
        end
    end

    assign out_tag     = tag3_reg;
    assign out_pixel   = pix_reg;
    assign out_clipped = clip_reg;

    a_clip_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        out_tag.valid && out_clipped |-> out_pixel == '0 || out_pixel == '1)
        else $error("clipped result not at 0 or 255");

endmodule

/* hw/rtl/conv3x3_image_filter.sv */
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------
// s_       | in        | s_valid / s_ready   | s_req_type, s_pixel
// m_       | out       | m_valid / m_ready   | m_out_pixel, m_clipped, m_frame_end
// cfg_     | in        | cfg_wr_en (no wait) | cfg_index, cfg_wdata
//
// One item per clock while the m_ port is not stalled. A result reaches the m_ port
// through one register each for the line-store read, window, products, row sums and
// saturated total, the first loaded at the edge that takes the item completing it.
// Reset (synchronous, aresetn low) clears counters, valid bits and the
// registers to their defaults; line stores are not cleared and need no pass.
// The whole pipeline holds while m_valid is high and m_ready low; s_ready
// follows that same condition, so a waiting result never blocks the stages
// behind it otherwise.
module conv3x3_image_filter #(
    parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [7:0]                          s_pixel,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_pixel,
    output logic                                m_clipped,
    output logic                                m_frame_end,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [conv3_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [conv3_pkg::KROW_BITS-1:0]     cfg_wdata
);
    import conv3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    // control carried with an item from the accept stage to the window stage
    typedef struct packed {
        logic valid;
        logic emit;      // item completes a result
        logic c0;        // column 0: right-edge result of the row before last
        logic c1;        // column 1: left-edge result, replicate left column
        logic top_rep;   // result on first row
        logic bot_rep;   // result on last row
        logic fe;        // result closes the frame
    } ctl_t;

    // ---------------- configuration registers ----------------
    logic [FW_BITS-1:0] frame_width_reg;
    logic [FH_BITS-1:0] frame_height_reg;
    kern_t              kern_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            kern_reg[0]      <= KERNEL_OUTER_RST;
            kern_reg[1]      <= KERNEL_CENTER_RST;
            kern_reg[2]      <= KERNEL_OUTER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:   frame_width_reg  <= cfg_wdata[FW_BITS-1:0];
                CFG_FRAME_HEIGHT:  frame_height_reg <= cfg_wdata[FH_BITS-1:0];
                CFG_KERNEL_TOP:    kern_reg[0]      <= cfg_wdata;
                CFG_KERNEL_MIDDLE: kern_reg[1]      <= cfg_wdata;
                CFG_KERNEL_BOTTOM: kern_reg[2]      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [FH_BITS-1:0]  fw_ext, fw_cl, h_eff;
    logic [COL_W:0]      w_eff;

    always_comb begin
        fw_ext = FH_BITS'(frame_width_reg);
        if (fw_ext < FH_BITS'(MIN_DIM)) begin
            fw_cl = FH_BITS'(MIN_DIM);
        end else if (fw_ext > FH_BITS'(MAX_WIDTH)) begin
            fw_cl = FH_BITS'(MAX_WIDTH);
        end else begin
            fw_cl = fw_ext;
        end
        w_eff = fw_cl[COL_W:0];

        if (frame_height_reg < FH_BITS'(MIN_DIM)) begin
            h_eff = FH_BITS'(MIN_DIM);
        end else if (frame_height_reg > FH_BITS'(MAX_HEIGHT)) begin
            h_eff = FH_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = frame_height_reg;
        end
    end

    // ---------------- accept stage ----------------
    logic                col_reg_wrap;
    logic [COL_W-1:0]    col_reg, col_next, c;
    logic [ROW_BITS-1:0] row_reg, row_next, r;
    logic [COL_W:0]      c_inc;
    logic                pix_phase, ignore, accept, adv;
    ctl_t                ctl_next;
    pix_t                px;

    tag_t                mac_out_tag;

    assign adv     = !mac_out_tag.valid || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // counters may sit past a narrowed width: wrap before use
        col_reg_wrap = {1'b0, col_reg} >= w_eff;
        c = col_reg_wrap ? '0 : col_reg;
        r = col_reg_wrap ? row_reg + ROW_BITS'(1) : row_reg;

        pix_phase = r < h_eff;
        // drain items are dropped while pixels are still due
        ignore    = pix_phase && s_req_type;
        px        = pix_phase ? s_pixel : '0;

        // stage advances only with adv, so s_valid here equals accept
        ctl_next.valid   = s_valid && !ignore;
        ctl_next.emit    = (r >= ROW_BITS'(2)) || (r == ROW_BITS'(1) && c != '0);
        ctl_next.c0      = c == '0;
        ctl_next.c1      = c == COL_W'(1);
        ctl_next.top_rep = ctl_next.c0 ? (r == ROW_BITS'(2)) : (r == ROW_BITS'(1));
        ctl_next.bot_rep = ctl_next.c0 ? (r > h_eff) : (r >= h_eff);
        ctl_next.fe      = ctl_next.emit && ctl_next.c0 && (r > h_eff);

        c_inc = {1'b0, c} + (COL_W+1)'(1);
        if (ctl_next.fe) begin
            col_next = '0;
            row_next = '0;
        end else if (ignore) begin
            col_next = c;
            row_next = r;
        end else if (c_inc >= w_eff) begin
            col_next = '0;
            row_next = r + ROW_BITS'(1);
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line stores ----------------
    // read at accept, written back one stage later: upper <- lower, lower <- pixel
    ctl_t             s2_ctl_reg;
    pix_t             s2_px_reg;
    logic [COL_W-1:0] s2_addr_reg;
    pix_t             rd_upper, rd_lower;
    logic             ram_rd, ram_wr;

    assign ram_rd = accept && !ignore;
    assign ram_wr = adv && s2_ctl_reg.valid;

    conv3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_upper (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (s2_addr_reg),
        .wr_data (rd_lower),
        .rd_en   (ram_rd),
        .rd_addr (c),
        .rd_data (rd_upper)
    );

    conv3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_lower (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (s2_addr_reg),
        .wr_data (s2_px_reg),
        .rd_en   (ram_rd),
        .rd_addr (c),
        .rd_data (rd_lower)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_ctl_reg <= '0;
        end else if (adv) begin
            s2_ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_px_reg   <= px;
            s2_addr_reg <= c;
        end
    end

    // ---------------- window stage ----------------
    win_t win_reg, win_next, nb_next, nb_reg;
    pix_t [KERNEL_SIZE-1:0] new_col;
    tag_t nb_tag_reg;

    always_comb begin
        new_col[0] = rd_upper;
        new_col[1] = rd_lower;
        new_col[2] = s2_px_reg;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
            win_next[i][2] = new_col[i];
            // column 0 closes the previous row from the old window, right edge doubled;
            // column 1 opens a row, left edge doubled
            nb_next[i][0] = s2_ctl_reg.c1 ? win_reg[i][2] : win_reg[i][1];
            nb_next[i][1] = win_reg[i][2];
            nb_next[i][2] = s2_ctl_reg.c0 ? win_reg[i][2] : new_col[i];
        end
        if (s2_ctl_reg.bot_rep) begin
            nb_next[2] = nb_next[1];
        end
        if (s2_ctl_reg.top_rep) begin
            nb_next[0] = nb_next[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_wr) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nb_reg <= nb_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nb_tag_reg <= '0;
        end else if (adv) begin
            nb_tag_reg.valid     <= s2_ctl_reg.valid && s2_ctl_reg.emit;
            nb_tag_reg.frame_end <= s2_ctl_reg.fe;
        end
    end

    // ---------------- multiply-accumulate and output register ----------------
    conv3_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_tag      (nb_tag_reg),
        .in_win      (nb_reg),
        .kern        (kern_reg),
        .out_tag     (mac_out_tag),
        .out_pixel   (m_out_pixel),
        .out_clipped (m_clipped)
    );

    assign m_valid     = mac_out_tag.valid;
    assign m_frame_end = mac_out_tag.frame_end;

    // a frame-closing item leaves the counters at the start of the next frame
    a_fe_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_ctl_reg.valid && s2_ctl_reg.fe |-> col_reg == '0 && row_reg == '0)
        else $error("counters not cleared after frame end");

    // first and last row never coincide since the height is at least three
    a_rep_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_ctl_reg.valid |-> !(s2_ctl_reg.top_rep && s2_ctl_reg.bot_rep))
        else $error("top and bottom replication together");

    // a taken item reaches the window stage with the address it read
    a_s2_load: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !ignore |=> s2_ctl_reg.valid && s2_addr_reg == $past(c))
        else $error("item lost between accept and window stage");

endmodule
